// File: rtl/bscre_pkg.sv
// ----------------------------------------------------------------------------
// bscre_pkg
// Shared types, constants and helpers for the bitmap set/clear range engine.
// ----------------------------------------------------------------------------
package bscre_pkg;

    localparam int NUM_WORDS = 32;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [31:0] CAPACITY = 32'(NUM_WORDS * 32);

    localparam logic [2:0] OP_SET_BIT    = 3'd0;
    localparam logic [2:0] OP_CLEAR_BIT  = 3'd1;
    localparam logic [2:0] OP_READ_BIT   = 3'd2;
    localparam logic [2:0] OP_SET_RANGE  = 3'd3;
    localparam logic [2:0] OP_CLR_RANGE  = 3'd4;
    localparam logic [2:0] OP_OR_WORD    = 3'd5;
    localparam logic [2:0] OP_ANDN_WORD  = 3'd6;
    localparam logic [2:0] OP_AND_WORD   = 3'd7;

    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [31:0]        wr_data;
    } t_mem_req;

    function automatic logic [WORD_AW-1:0] pos_word(input logic [9:0] pos);
        logic [31:0] w;
        w = 32'(pos) >> 5;
        return w[WORD_AW-1:0];
    endfunction

    function automatic logic [WORD_AW-1:0] word_addr(input logic [4:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[WORD_AW-1:0];
    endfunction

endpackage

// File: rtl/bitmap_set_clear_range_engine_core.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_range_engine_core
// Bitmap of 32-bit words with single-bit, range and word-merge requests.
// ----------------------------------------------------------------------------
// A request transaction is accepted when i_start is high and o_busy is low.
// Each request produces one result on o_bit_value and o_range_error, shown
// for exactly one cycle with o_valid high; the receiver cannot stall it.
// A single-bit or word-merge request reads its word from the store in the
// accept cycle and writes it back in the next (a read-bit request writes
// nothing); the result appears in the cycle after that, when the next
// request may enter. A range request walks its words through the same
// read-modify-write loop, one word per cycle.
// A rejected request changes nothing.
// After reset the whole bitmap reads as zeros and the engine is idle.
// ----------------------------------------------------------------------------
module bitmap_set_clear_range_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_first_pos,
    input  logic [9:0]  i_last_pos,
    input  logic [4:0]  i_word_index,
    input  logic [31:0] i_word_value,
    output logic        o_busy,
    output logic        o_valid,
    output logic        o_bit_value,
    output logic        o_range_error
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WR   = 1'b1;

    logic                          r_state, n_state;
    logic [2:0]                    r_op;
    logic [9:0]                    r_first;
    logic [9:0]                    r_last;
    logic [31:0]                   r_wv;
    logic [bscre_pkg::WORD_AW-1:0] r_addr, n_addr;
    logic                          r_valid, n_valid;
    logic                          r_bit, n_bit;
    logic                          r_err, n_err;

    logic                          accept;
    logic                          req_err;
    logic [bscre_pkg::WORD_AW-1:0] start_addr;
    logic [31:0]                   rd_data;
    logic [31:0]                   mask;
    logic [31:0]                   new_word;
    logic                          last_word;
    bscre_pkg::t_mem_req           mem_req;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        req_err    = 1'b0;
        start_addr = bscre_pkg::pos_word(i_first_pos);
        if (i_req_type <= bscre_pkg::OP_READ_BIT) begin
            req_err = 32'(i_first_pos) >= bscre_pkg::CAPACITY;
        end else if (i_req_type <= bscre_pkg::OP_CLR_RANGE) begin
            req_err = (32'(i_last_pos) >= bscre_pkg::CAPACITY) || (i_first_pos > i_last_pos);
        end else begin
            req_err    = 32'(i_word_index) >= 32'(bscre_pkg::NUM_WORDS);
            start_addr = bscre_pkg::word_addr(i_word_index);
        end
    end

    assign last_word = (r_addr == bscre_pkg::pos_word(r_last));

    always_comb begin
        mask = 32'hFFFF_FFFF;
        if (r_op <= bscre_pkg::OP_READ_BIT) begin
            mask = 32'd1 << r_first[4:0];
        end else begin
            if (r_addr == bscre_pkg::pos_word(r_first)) begin
                mask = mask & (32'hFFFF_FFFF << r_first[4:0]);
            end
            if (last_word) begin
                mask = mask & (32'hFFFF_FFFF >> (~r_last[4:0]));
            end
        end
        case (r_op)
            bscre_pkg::OP_SET_BIT,
            bscre_pkg::OP_SET_RANGE:  new_word = rd_data | mask;
            bscre_pkg::OP_CLEAR_BIT,
            bscre_pkg::OP_CLR_RANGE:  new_word = rd_data & ~mask;
            bscre_pkg::OP_OR_WORD:    new_word = rd_data | r_wv;
            bscre_pkg::OP_ANDN_WORD:  new_word = rd_data & ~r_wv;
            bscre_pkg::OP_AND_WORD:   new_word = rd_data & r_wv;
            default:                  new_word = rd_data;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_valid = 1'b0;
        n_bit   = r_bit;
        n_err   = r_err;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_addr;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_addr;
        mem_req.wr_data = new_word;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (req_err) begin
                        n_valid = 1'b1;
                        n_bit   = 1'b0;
                        n_err   = 1'b1;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = start_addr;
                        n_addr          = start_addr;
                        n_state         = ST_WR;
                    end
                end
            end
            ST_WR: begin
                mem_req.wr_en = (r_op != bscre_pkg::OP_READ_BIT);
                if ((r_op == bscre_pkg::OP_SET_RANGE || r_op == bscre_pkg::OP_CLR_RANGE)
                        && !last_word) begin
                    n_addr          = r_addr + bscre_pkg::WORD_AW'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = n_addr;
                end else begin
                    n_valid = 1'b1;
                    n_bit   = (r_op == bscre_pkg::OP_READ_BIT) ? |(rd_data & mask) : 1'b0;
                    n_err   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_bit  <= n_bit;
        r_err  <= n_err;
        if (accept) begin
            r_op    <= i_req_type;
            r_first <= i_first_pos;
            r_last  <= i_last_pos;
            r_wv    <= i_word_value;
        end
    end

    bscre_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_busy        = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_bit_value   = r_bit;
    assign o_range_error = r_err;

endmodule

// File: rtl/bscre_mem.sv
// ----------------------------------------------------------------------------
// bscre_mem
// Bitmap word store with a registered read port and per-word valid bits
// that make unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module bscre_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bscre_pkg::t_mem_req i_req,
    output logic [31:0]        o_rd_data
);

    logic [31:0]                  r_mem [bscre_pkg::NUM_WORDS];
    logic [bscre_pkg::NUM_WORDS-1:0] r_valid;
    logic [31:0]                  r_rd_data;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 32'd0;

endmodule
